// ===== rtl/core/pbts_pkg.sv =====
package pbts_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] tone_hz;
        logic [15:0] duration_ms;
    } t_in_word;

    typedef struct packed {
        logic [15:0] duty_level;
        logic [11:0] clock_divider;
        logic [13:0] frames_left;
        logic        gap_active;
    } t_out_word;

    localparam logic        MODE_TICK      = 1'b0;
    localparam logic        MODE_BEEP      = 1'b1;

    localparam logic        REG_SYS_CLK    = 1'b0;
    localparam logic        REG_FRAME_RATE = 1'b1;

    localparam logic [27:0] SYS_CLK_RESET    = 28'd125000000;
    localparam logic [7:0]  FRAME_RATE_RESET = 8'd60;

    localparam logic [11:0] DIV_MIN  = 12'd16;
    localparam logic [11:0] DIV_MAX  = 12'd4080;
    localparam logic [9:0]  MS_PER_S = 10'd1000;

    // ceil(2^34 / 1000): exact floor(x / 1000) for any x below 2^24
    localparam logic [24:0] MS_RECIP       = 25'd17179870;
    localparam int          MS_RECIP_SHIFT = 34;

endpackage

// ===== rtl/core/pwm_beep_tone_sequencer_core.sv =====
// Channel   Direction  Handshake                    Word
// input     in         i_in_valid / o_in_ready      pbts_pkg::t_in_word
// output    out        o_out_valid / i_out_ready    pbts_pkg::t_out_word
// config    in         psel/penable/pwrite, pready  32-bit APB register write
//
// A tick goes straight to S_DONE, or through S_START and the divider when it ends the gap and
// starts a pending tone (straight from S_START to S_DONE if silent). A beep request runs S_MUL,
// S_RECIP and S_FRAMES, then S_DONE when it preempts and S_START onward otherwise: frames come from
// a reciprocal multiply, the PWM divider from one 32-step pass of the serial divider.
// Synchronous active-low reset clears all tone state; divider resets to 1.0.
// A word still waiting in the output register stalls the sequencer before its next write.
module pwm_beep_tone_sequencer_core #(
    parameter int PWM_WRAP_TOP = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pbts_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbts_pkg::t_out_word o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int          TopW = $clog2(PWM_WRAP_TOP + 2);
    localparam int          DenW = 16 + TopW;
    localparam int          NumW = 32;
    localparam logic [15:0] Half = 16'((PWM_WRAP_TOP + 1) / 2);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_RECIP, S_FRAMES, S_START, S_QGO, S_QWAIT, S_DONE
    } t_state;

    t_state r_state;

    logic [27:0] w_sys_clk_hz;
    logic [7:0]  w_frame_rate;

    logic [15:0]     r_hz;
    logic [15:0]     r_ms;
    logic [23:0]     r_prod;
    logic [14:0]     r_frames_q;
    logic [15:0]     r_start_hz;
    logic [DenW-1:0] r_den;

    logic [13:0] r_tone_left;
    logic        r_gap;
    logic [15:0] r_pend_hz;
    logic [13:0] r_hold_frames;
    logic [11:0] r_div;
    logic [15:0] r_level;

    logic                r_out_valid;
    pbts_pkg::t_out_word r_out_word;

    logic            w_div_start;
    logic [NumW-1:0] w_div_num;
    logic [DenW-1:0] w_div_den;
    logic            w_div_done;
    logic [NumW-1:0] w_div_quot;
    logic [48:0]     w_recip_prod;
    logic [13:0]     w_frames;
    logic [11:0]     w_clamped;
    logic            w_out_load;

    pbts_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_sys_clk_hz (w_sys_clk_hz),
        .o_frame_rate (w_frame_rate)
    );

    // serial divider: clk*16/den for the PWM divider
    assign w_div_start = (r_state == S_QGO);
    assign w_div_num   = {w_sys_clk_hz, 4'b0};
    assign w_div_den   = r_den;

    pbts_div #(
        .N (NumW),
        .D (DenW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // ms*rate/1000 as a multiply by the scaled reciprocal
    assign w_recip_prod = 49'(r_prod) * 49'(pbts_pkg::MS_RECIP);

    // a zero frame count becomes one, then the count wraps to 14 bits
    assign w_frames = (r_frames_q == '0) ? 14'd1 : r_frames_q[13:0];

    always_comb begin
        if (w_div_quot < NumW'(pbts_pkg::DIV_MIN)) begin
            w_clamped = pbts_pkg::DIV_MIN;
        end else if (w_div_quot > NumW'(pbts_pkg::DIV_MAX)) begin
            w_clamped = pbts_pkg::DIV_MAX;
        end else begin
            w_clamped = w_div_quot[11:0];
        end
    end

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tone_left   <= '0;
            r_gap         <= 1'b0;
            r_pend_hz     <= '0;
            r_hold_frames <= '0;
            r_div         <= pbts_pkg::DIV_MIN;
            r_level       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_hz <= i_in_word.tone_hz;
                        r_ms <= i_in_word.duration_ms;
                        if (i_in_word.mode == pbts_pkg::MODE_BEEP) begin
                            r_state <= S_MUL;
                        end else if (r_gap) begin
                            r_gap       <= 1'b0;
                            r_start_hz  <= r_pend_hz;
                            r_tone_left <= r_hold_frames;
                            r_state     <= S_START;
                        end else begin
                            if (r_tone_left != '0) begin
                                r_tone_left <= r_tone_left - 1'b1;
                                if (r_tone_left == 14'd1) begin
                                    r_level <= '0;
                                end
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= 24'(r_ms) * 24'(w_frame_rate);
                    r_state <= S_RECIP;
                end
                S_RECIP: begin
                    r_frames_q <= w_recip_prod[pbts_pkg::MS_RECIP_SHIFT +: 15];
                    r_state    <= S_FRAMES;
                end
                S_FRAMES: begin
                    if (r_tone_left != '0 || r_gap) begin
                        // silence now, hold the new tone behind a one-frame gap
                        r_level       <= '0;
                        r_tone_left   <= '0;
                        r_gap         <= 1'b1;
                        r_pend_hz     <= r_hz;
                        r_hold_frames <= w_frames;
                        r_state       <= S_DONE;
                    end else begin
                        r_tone_left <= w_frames;
                        r_start_hz  <= r_hz;
                        r_state     <= S_START;
                    end
                end
                S_START: begin
                    if (r_start_hz == '0) begin
                        r_level <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_den   <= DenW'(r_start_hz) * DenW'(PWM_WRAP_TOP + 1);
                        r_state <= S_QGO;
                    end
                end
                S_QGO: begin
                    r_state <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (w_div_done) begin
                        r_div   <= w_clamped;
                        r_level <= Half;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_word.duty_level    <= r_level;
                        r_out_word.clock_divider <= r_div;
                        r_out_word.frames_left   <= r_tone_left;
                        r_out_word.gap_active    <= r_gap;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/pbts_div.sv =====
module pbts_div #(
    parameter int N = 32,
    parameter int D = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quot
);

    localparam int CW = $clog2(N + 1);

    logic [D-1:0]  r_rem;
    logic [N-1:0]  r_quo;
    logic [D-1:0]  r_dsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [D:0]    w_trial;
    logic          w_ge;
    logic [D:0]    w_diff;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    assign w_trial = {r_rem, r_quo[N-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
                r_cnt  <= CW'(N);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[D-1:0] : w_trial[D-1:0];
                r_quo <= {r_quo[N-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/core/pbts_regs.sv =====
module pbts_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [27:0] o_sys_clk_hz,
    output logic [7:0]  o_frame_rate
);

    logic [27:0] r_sys_clk_hz;
    logic [7:0]  r_frame_rate;
    logic        w_index;

    assign w_index = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_clk_hz <= pbts_pkg::SYS_CLK_RESET;
            r_frame_rate <= pbts_pkg::FRAME_RATE_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_index)
                pbts_pkg::REG_SYS_CLK:    r_sys_clk_hz <= pwdata[27:0];
                pbts_pkg::REG_FRAME_RATE: r_frame_rate <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            pbts_pkg::REG_SYS_CLK:    prdata = {4'b0, r_sys_clk_hz};
            pbts_pkg::REG_FRAME_RATE: prdata = {24'b0, r_frame_rate};
            default:                  prdata = '0;
        endcase
    end

    assign o_sys_clk_hz = r_sys_clk_hz;
    assign o_frame_rate = r_frame_rate;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int PWM_TOP        = 255;
    localparam int STALL_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 80;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    pbts_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    pbts_pkg::t_out_word o_out_word;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // tone predictor state and its copy of the registers
    logic [27:0] cfg_sysclk  = pbts_pkg::SYS_CLK_RESET;
    logic [7:0]  cfg_rate    = pbts_pkg::FRAME_RATE_RESET;
    logic [13:0] tone_left   = '0;
    logic        gap_on      = 1'b0;
    logic [15:0] pend_hz     = '0;
    logic [13:0] hold_frames = '0;
    logic [11:0] div_now     = pbts_pkg::DIV_MIN;
    logic [15:0] level_now   = '0;

    pbts_pkg::t_out_word due_status[$];
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;
    logic                calm           = 1'b0;

    pwm_beep_tone_sequencer_core #(
        .PWM_WRAP_TOP(PWM_TOP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void launch_tone(input logic [15:0] hz);
        longint unsigned q;
        if (hz == 16'd0) begin
            level_now = '0;
        end else begin
            q = (longint'(cfg_sysclk) * 64'd16) / (longint'(hz) * longint'(PWM_TOP + 1));
            if (q < pbts_pkg::DIV_MIN) q = pbts_pkg::DIV_MIN;
            if (q > pbts_pkg::DIV_MAX) q = pbts_pkg::DIV_MAX;
            div_now   = q[11:0];
            level_now = 16'((PWM_TOP + 1) / 2);
        end
    endfunction

    function automatic pbts_pkg::t_out_word advance_tone(input pbts_pkg::t_in_word w);
        logic [31:0]         frames_full;
        logic [13:0]         frames;
        pbts_pkg::t_out_word o;
        if (w.mode == pbts_pkg::MODE_BEEP) begin
            frames_full = (32'(w.duration_ms) * 32'(cfg_rate)) / 32'(pbts_pkg::MS_PER_S);
            if (frames_full < 32'd1) frames_full = 32'd1;
            frames = frames_full[13:0];
            if (tone_left != '0 || gap_on) begin
                // silence now, hold the new tone behind a one-frame gap
                level_now   = '0;
                tone_left   = '0;
                gap_on      = 1'b1;
                pend_hz     = w.tone_hz;
                hold_frames = frames;
            end else begin
                launch_tone(w.tone_hz);
                tone_left = frames;
            end
        end else begin
            if (gap_on) begin
                gap_on = 1'b0;
                launch_tone(pend_hz);
                tone_left = hold_frames;
            end else if (tone_left != '0) begin
                tone_left = tone_left - 14'd1;
                if (tone_left == '0) level_now = '0;
            end
        end
        o.duty_level    = level_now;
        o.clock_divider = div_now;
        o.frames_left   = tone_left;
        o.gap_active    = gap_on;
        return o;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // check each result word and drive the receiver's stalls
    always @(posedge i_clk) begin
        pbts_pkg::t_out_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_status.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, o_out_word);
                mismatch_count++;
            end else begin
                exp_w = due_status.pop_front();
                compare_field("duty_level", exp_w.duty_level, o_out_word.duty_level);
                compare_field("clock_divider", exp_w.clock_divider,
                              o_out_word.clock_divider);
                compare_field("frames_left", exp_w.frames_left, o_out_word.frames_left);
                compare_field("gap_active", exp_w.gap_active, o_out_word.gap_active);
            end
        end
        i_out_ready <= calm || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input pbts_pkg::t_in_word w);
        // idle the input now and then, deciding afresh at each clock
        while (!calm && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        due_status.push_back(advance_tone(w));
    endtask

    task automatic send_beep(input logic [15:0] hz, input logic [15:0] ms);
        send_word('{mode: pbts_pkg::MODE_BEEP, tone_hz: hz, duration_ms: ms});
    endtask

    task automatic send_tick();
        send_word('{mode: pbts_pkg::MODE_TICK, tone_hz: 16'($urandom),
                    duration_ms: 16'($urandom)});
    endtask

    // wait out every expected word, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (due_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] expect_rd;
        expect_rd = (idx == pbts_pkg::REG_SYS_CLK) ? (value & 32'h0FFF_FFFF)
                                                    : (value & 32'h0000_00FF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == pbts_pkg::REG_SYS_CLK) cfg_sysclk = value[27:0];
        else cfg_rate = value[7:0];
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== expect_rd) begin
            $display("%0t: register %0d readback, expected %h, actual %h",
                     $time, idx, expect_rd, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] sysclk, input logic [31:0] rate);
        drain();
        write_reg(pbts_pkg::REG_SYS_CLK, sysclk);
        write_reg(pbts_pkg::REG_FRAME_RATE, rate);
    endtask

    function automatic pbts_pkg::t_in_word rand_word();
        pbts_pkg::t_in_word w;
        int unsigned        pick;
        w.mode        = pbts_pkg::MODE_TICK;
        w.tone_hz     = 16'($urandom);
        w.duration_ms = 16'($urandom);
        pick = $urandom_range(99);
        if (pick >= 55) begin
            w.mode = pbts_pkg::MODE_BEEP;
            pick = $urandom_range(99);
            if (pick < 10) w.tone_hz = '0;
            else if (pick < 80) w.tone_hz = 16'($urandom_range(20000, 20));
            // keep most beeps short so they run down to silence
            pick = $urandom_range(99);
            if (pick < 70) w.duration_ms = 16'($urandom_range(300));
            else if (pick < 90) w.duration_ms = 16'($urandom_range(3000));
        end
        return w;
    endfunction

    task automatic test_reset_defaults();
        send_tick();
        send_beep(16'd0, 16'd0);
        send_tick();
        send_tick();
    endtask

    task automatic test_preempt_and_gap();
        send_beep(16'd440, 16'd50);
        send_beep(16'd1000, 16'd100);
        send_beep(16'hFFFF, 16'd16);
        send_tick();
        send_tick();
        send_beep(16'd880, 16'd20);
        send_tick();
    endtask

    task automatic test_extreme_fields();
        send_beep(16'hFFFF, 16'hFFFF);
        send_beep(16'd1, 16'd1);
        send_tick();
        send_beep(16'd0, 16'hFFFF);
        send_tick();
    endtask

    task automatic test_divider_clamps();
        apply_settings(32'd1000000, 32'd240);
        send_beep(16'hFFFF, 16'd1000);
        send_beep(16'd1, 16'd5);
        send_tick();
        apply_settings(32'd0, 32'd60);
        send_beep(16'd1000, 16'd10);
        send_tick();
    endtask

    task automatic test_zero_frame_rate();
        apply_settings(32'(pbts_pkg::SYS_CLK_RESET), 32'd0);
        send_beep(16'd500, 16'hFFFF);
        send_tick();
        send_tick();
    endtask

    task automatic test_random_traffic(input int count, input logic [31:0] sysclk,
                                       input logic [31:0] rate, input logic quiet);
        apply_settings(sysclk, rate);
        calm <= quiet;
        repeat (count) send_word(rand_word());
        calm <= 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_preempt_and_gap();
        test_extreme_fields();
        test_divider_clamps();
        test_zero_frame_rate();

        test_random_traffic(150, 32'd268435455, 32'd240, 1'b0);
        test_random_traffic(150, 32'd1000000, 32'd1, 1'b0);
        test_random_traffic(100, 32'd0, 32'd0, 1'b0);
        test_random_traffic(100, $urandom_range(268435455, 1000000), $urandom_range(240, 1),
                            1'b1);
        test_random_traffic(100, $urandom_range(268435455, 1000000), $urandom_range(240, 1),
                            1'b0);
        test_random_traffic(100, $urandom_range(268435455, 1000000), $urandom_range(240, 1),
                            1'b0);
        test_random_traffic(150, 32'(pbts_pkg::SYS_CLK_RESET),
                            32'(pbts_pkg::FRAME_RATE_RESET), 1'b0);

        drain();
        if (mismatch_count == 0 && due_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
